/* rtl/core/iss_pkg.sv */
// Shared constants, codes and control types for the indexed sequence store.
package iss_pkg;

   // Storage geometry
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Port field widths
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int RDATA_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Width for position/count comparisons
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Command codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_AT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd7;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the incoming command
      logic exec;   // run the held command and register its result
   } dp_cmd_type;

endpackage

/* rtl/core/iss_datapath.sv */
// Datapath: element register chain, count, command hold and result registers.
module iss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  iss_pkg::dp_cmd_type           cmd,
   input  logic [iss_pkg::FUNC_W-1:0]    req_func,
   input  logic [iss_pkg::POS_W-1:0]     req_position,
   input  logic [iss_pkg::VALUE_W-1:0]   req_value,
   output logic [iss_pkg::RDATA_W-1:0]   rsp_read_data,
   output logic [iss_pkg::COUNT_W-1:0]   rsp_count,
   output logic [iss_pkg::STATUS_W-1:0]  rsp_status
);
   import iss_pkg::*;

   logic [FUNC_W-1:0]     func_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] value_ff;

   logic [DATA_WIDTH-1:0] elem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] elem_in [DEPTH];
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   logic [DATA_WIDTH-1:0] rd_ff;
   logic [DATA_WIDTH-1:0] rd_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;

   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      eff_pos;
   logic [IDX_W-1:0]      eff_idx;
   logic                  is_full;
   logic                  is_empty;
   logic                  do_ins;
   logic                  do_rem;

   // Command hold
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         pos_ff   <= req_position;
         value_ff <= req_value[DATA_WIDTH-1:0];
      end
   end

   // Decode and check
   always_comb begin
      pos_ext   = CMP_W'(pos_ff);
      cnt_ext   = CMP_W'(count_ff);
      is_full   = (count_ff == CNT_W'(DEPTH));
      is_empty  = (count_ff == '0);
      eff_pos   = pos_ext;
      status_in = STATUS_OK;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      count_in  = count_ff;
      rd_in     = '0;
      unique case (func_ff)
         FUNC_PUSH_BACK, FUNC_PUSH_FRONT, FUNC_INSERT: begin
            if (func_ff == FUNC_PUSH_BACK) begin
               eff_pos = cnt_ext;
            end else if (func_ff == FUNC_PUSH_FRONT) begin
               eff_pos = '0;
            end
            if (is_full) begin
               status_in = STATUS_FULL;
            end else if (func_ff == FUNC_INSERT && pos_ext > cnt_ext) begin
               status_in = STATUS_RANGE;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE_AT, FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_READ: begin
            if (func_ff == FUNC_POP_FRONT) begin
               eff_pos = '0;
            end else if (func_ff == FUNC_POP_BACK) begin
               eff_pos = cnt_ext - CMP_W'(1);
            end
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else if ((func_ff == FUNC_REMOVE_AT || func_ff == FUNC_READ)
                         && pos_ext >= cnt_ext) begin
               status_in = STATUS_RANGE;
            end else begin
               rd_in = elem_ff[eff_idx];
               if (func_ff != FUNC_READ) begin
                  do_rem   = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign eff_idx = eff_pos[IDX_W-1:0];

   // Per-entry shift selection
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         elem_in[i] = elem_ff[i];
         if (do_ins) begin
            if (CMP_W'(i) == eff_pos) begin
               elem_in[i] = value_ff;
            end else if (CMP_W'(i) > eff_pos) begin
               elem_in[i] = elem_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_rem) begin
            if (CMP_W'(i) >= eff_pos && i + 1 < DEPTH) begin
               elem_in[i] = elem_ff[(i + 1 < DEPTH) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            elem_ff[i] <= elem_in[i];
         end
         rd_ff     <= rd_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // Count only moves on exec, which waits for the result register to drain
   assign rsp_read_data = RDATA_W'(rd_ff);
   assign rsp_count     = COUNT_W'(count_ff);
   assign rsp_status    = status_ff;

endmodule

/* rtl/core/iss_ctrl.sv */
// Controller: command hold sequencing and result register handshake.
module iss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output iss_pkg::dp_cmd_type  cmd
);
   import iss_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.exec     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/core/indexed_sequence_store.sv */
// Top level: ordered sequence store with insert/remove at position.
// Flow: capture into the command hold, then execute into the result register when free.
// Requests stall until the held command executes; the command hold register accepts
//   the next transfer while the previous result waits in the result register.
// Reset (synchronous, active high) clears the count and the handshake state;
//   element contents stay undefined until written.
module indexed_sequence_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [iss_pkg::FUNC_W-1:0]    req_func,
   input  logic [iss_pkg::POS_W-1:0]     req_position,
   input  logic [iss_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [iss_pkg::RDATA_W-1:0]   rsp_read_data,
   output logic [iss_pkg::COUNT_W-1:0]   rsp_count,
   output logic [iss_pkg::STATUS_W-1:0]  rsp_status
);
   import iss_pkg::*;

   // Load/execute strobes from the controller to the datapath
   dp_cmd_type cmd;

   // Sequence the capture and execute steps, and own the stall and valid outputs
   iss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Hold the element chain, the count and the registered result; each insert or
   // remove shifts every entry past the position by one place at once
   iss_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_func      (req_func),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_read_data (rsp_read_data),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

endmodule
